// ===== src/idetf_pkg.sv =====
// ----------------------------------------------------------------------------
// idetf_pkg
// Shared types and constants for the IDE task-file register block.
// ----------------------------------------------------------------------------
package idetf_pkg;

	localparam int BufferBytes = 512;
	localparam int BufAw       = $clog2(BufferBytes);
	localparam int RemW        = 17;
	localparam int SectorBits  = 9;
	localparam int OutqDepth   = 4;
	localparam int OutqAw      = $clog2(OutqDepth);
	localparam int OutqCw      = $clog2(OutqDepth + 1);

	localparam logic [3:0] CmdRecalNibble = 4'h1;
	localparam logic [7:0] CmdReadSec     = 8'h20;
	localparam logic [7:0] CmdReadSecNr   = 8'h21;
	localparam logic [7:0] CmdWriteSec    = 8'h30;
	localparam logic [7:0] CmdWriteSecNr  = 8'h31;
	localparam logic [7:0] DataIdle       = 8'hFF;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_DATA       = 3'd0,
		REG_ERROR      = 3'd1,
		REG_COUNT      = 3'd2,
		REG_SECTOR     = 3'd3,
		REG_CYL_LO     = 3'd4,
		REG_CYL_HI     = 3'd5,
		REG_DRV_HEAD   = 3'd6,
		REG_CMD_STATUS = 3'd7
	} reg_off_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [BufAw-1:0] addr;
		logic [7:0]       wdata;
	} mem_req_t;

	typedef struct packed {
		logic       from_mem;
		logic [7:0] value;
	} rd_res_t;

endpackage

// ===== src/ide_task_file_registers.sv =====
// ----------------------------------------------------------------------------
// ide_task_file_registers
// ATA task-file register block for two drives with an internal sector buffer.
// ----------------------------------------------------------------------------
// Each request on the s_axis side is one register access: tuser[0] is the
// operation (0 read, 1 write), tdata carries the offset and the write byte.
// Every request yields exactly one response on m_axis: the byte read, or
// zero for a write.
// Throughput is one request per cycle while s_axis_tready is high. A response
// becomes valid after its request passes the registered sector buffer read
// stage and then the result queue.
// After reset the sector buffer is zero-filled, one byte per cycle;
// s_axis_tready stays low during that pass.
// When the receiver stalls, responses collect in a four-entry queue and
// s_axis_tready drops once the queue and the read stage hold four entries;
// it does not depend combinationally on m_axis_tready.
// ----------------------------------------------------------------------------
module ide_task_file_registers import idetf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [2:0] reg_offset, [10:3] write_data
	input  logic [0:0]  s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [7:0] read_data
);

	logic              accept;
	mem_req_t          mem_req;
	rd_res_t           res;
	logic [7:0]        rd_data;
	logic              clr_done;
	logic              valid_s1;
	logic              from_mem_s1;
	logic [7:0]        value_s1;
	logic [7:0]        data_s1;
	logic [OutqCw-1:0] q_count;
	logic [OutqCw:0]   occ;
	logic              pop;

	assign occ           = {1'b0, q_count} + (OutqCw + 1)'(valid_s1);
	assign s_axis_tready = clr_done && (occ < (OutqCw + 1)'(OutqDepth));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;

	idetf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (op_t'(s_axis_tuser[0])),
		.reg_offset (reg_off_t'(s_axis_tdata[2:0])),
		.write_data (s_axis_tdata[10:3]),
		.mem_req    (mem_req),
		.res        (res)
	);

	idetf_sbuf u_sbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_data  (rd_data),
		.clr_done (clr_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= res.from_mem;
			value_s1    <= res.value;
		end
	end

	assign data_s1 = from_mem_s1 ? rd_data : value_s1;

	idetf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (data_s1),
		.pop       (pop),
		.not_empty (m_axis_tvalid),
		.head_data (m_axis_tdata),
		.count     (q_count)
	);

endmodule

// ===== src/idetf_sbuf.sv =====
// ----------------------------------------------------------------------------
// idetf_sbuf
// Sector buffer memory, registered read, zero-fill pass after reset.
// ----------------------------------------------------------------------------
module idetf_sbuf import idetf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rd_data,
	output logic       clr_done
);

	logic [7:0]       mem [BufferBytes];
	logic [7:0]       rd_q;
	logic [BufAw-1:0] clr_idx_q;
	logic             clr_busy_q;
	logic             we;
	logic [BufAw-1:0] waddr;
	logic [7:0]       wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BufAw'(BufferBytes - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign we    = clr_busy_q | req.wr_en;
	assign waddr = clr_busy_q ? clr_idx_q : req.addr;
	assign wdata = clr_busy_q ? 8'h00 : req.wdata;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_done = ~clr_busy_q;

endmodule

// ===== src/idetf_regs.sv =====
// ----------------------------------------------------------------------------
// idetf_regs
// Per-drive task-file registers, command decode and data-port pointer.
// ----------------------------------------------------------------------------
module idetf_regs import idetf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  op_t        operation,
	input  reg_off_t   reg_offset,
	input  logic [7:0] write_data,
	output mem_req_t   mem_req,
	output rd_res_t    res
);

	logic             sel_q;
	logic             lba_q     [2];
	logic [15:0]      cyl_q     [2];
	logic [3:0]       head_q    [2];
	logic [27:0]      lba_val_q [2];
	logic [7:0]       cnt_q     [2];
	logic [RemW-1:0]  rem_q;
	logic [BufAw-1:0] idx_q;
	logic [BufAw-1:0] idx_nxt;
	logic             data_live;
	logic             drv;
	logic             rw_cmd;

	assign drv       = sel_q;
	assign data_live = (rem_q != '0);
	assign idx_nxt   = (idx_q == BufAw'(BufferBytes - 1)) ? '0 : idx_q + 1'b1;
	assign rw_cmd    = (write_data == CmdReadSec) || (write_data == CmdReadSecNr) ||
	                   (write_data == CmdWriteSec) || (write_data == CmdWriteSecNr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				lba_q[i]     <= 1'b0;
				cyl_q[i]     <= '0;
				head_q[i]    <= '0;
				lba_val_q[i] <= '0;
				cnt_q[i]     <= '0;
			end
			rem_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (operation == OP_WRITE) begin
				unique case (reg_offset)
					REG_DATA: begin
						if (data_live) begin
							idx_q <= idx_nxt;
							rem_q <= rem_q - 1'b1;
						end
					end
					REG_ERROR: begin
					end
					REG_COUNT: begin
						cnt_q[drv] <= write_data;
					end
					REG_SECTOR: begin
						if (lba_q[drv]) begin
							lba_val_q[drv][7:0] <= write_data;
						end else begin
							lba_val_q[drv] <= {20'd0, write_data};
						end
					end
					REG_CYL_LO: begin
						if (lba_q[drv]) begin
							lba_val_q[drv][15:8] <= write_data;
						end else begin
							cyl_q[drv][7:0] <= write_data;
						end
					end
					REG_CYL_HI: begin
						if (lba_q[drv]) begin
							lba_val_q[drv][23:16] <= write_data;
						end else begin
							cyl_q[drv][15:8] <= write_data;
						end
					end
					REG_DRV_HEAD: begin
						sel_q              <= write_data[4];
						lba_q[write_data[4]] <= write_data[6];
						if (write_data[6]) begin
							lba_val_q[write_data[4]][27:24] <= write_data[3:0];
						end else begin
							head_q[write_data[4]] <= write_data[3:0];
						end
					end
					REG_CMD_STATUS: begin
						if (write_data[7:4] == CmdRecalNibble) begin
							cyl_q[drv] <= '0;
						end else if (rw_cmd) begin
							idx_q <= '0;
							rem_q <= {cnt_q[drv], {SectorBits{1'b0}}};
						end
					end
				endcase
			end else if (reg_offset == REG_DATA && data_live) begin
				idx_q <= idx_nxt;
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_comb begin
		mem_req.rd_en = accept && (operation == OP_READ) && (reg_offset == REG_DATA) && data_live;
		mem_req.wr_en = accept && (operation == OP_WRITE) && (reg_offset == REG_DATA) && data_live;
		mem_req.addr  = idx_q;
		mem_req.wdata = write_data;

		res.from_mem = 1'b0;
		res.value    = 8'h00;
		if (operation == OP_READ) begin
			unique case (reg_offset)
				REG_DATA: begin
					res.from_mem = data_live;
					res.value    = DataIdle;
				end
				REG_COUNT:  res.value = cnt_q[drv];
				REG_SECTOR: res.value = lba_val_q[drv][7:0];
				REG_CYL_LO: res.value = lba_q[drv] ? lba_val_q[drv][15:8] : cyl_q[drv][7:0];
				REG_CYL_HI: res.value = lba_q[drv] ? lba_val_q[drv][23:16] : cyl_q[drv][15:8];
				REG_DRV_HEAD: begin
					res.value = {1'b1, lba_q[drv], 1'b1, drv,
					             lba_q[drv] ? lba_val_q[drv][27:24] : head_q[drv]};
				end
				REG_ERROR, REG_CMD_STATUS: res.value = 8'h00;
			endcase
		end
	end

endmodule

// ===== src/idetf_outq.sv =====
// ----------------------------------------------------------------------------
// idetf_outq
// Small result queue decoupling the pipeline from the downstream ready.
// ----------------------------------------------------------------------------
module idetf_outq import idetf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        push_data,
	input  logic              pop,
	output logic              not_empty,
	output logic [7:0]        head_data,
	output logic [OutqCw-1:0] count
);

	logic [7:0]        slot_q [OutqDepth];
	logic [OutqAw-1:0] wr_ptr_q;
	logic [OutqAw-1:0] rd_ptr_q;
	logic [OutqCw-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (count_q != '0);
	assign head_data = slot_q[rd_ptr_q];
	assign count     = count_q;

endmodule
